// File: rtl/core/jnv_pkg.sv
`timescale 1ns / 1ps

package jnv_pkg;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    ST_SCAN     = 3'd0,
    ST_DONE     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_ENDED    = 3'd3,
    ST_DEEP     = 3'd4,
    ST_OPENER   = 3'd5,
    ST_LONG     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_SCAN = 2'b10
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       doc_start;
  } jnv_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] end_index;
    logic [6:0]  nest_depth;
  } jnv_out_t;

endpackage

// File: rtl/core/json_nesting_validator.sv
`timescale 1ns / 1ps
// Results are registered: each lands in the output register, or in the skid entry while the output is held.
// Throughput: one byte per cycle while the skid entry is empty, including runs of pushes and pops;
//   the stack memory is read one step ahead so each byte costs one top compare.
// Reset (rst_n, synchronous, active low): scanner idle, depth, quote flag and
//   position cleared, output stages empty. Stack memory is not cleared.
module json_nesting_validator
  import jnv_pkg::*;
#(
  parameter int MAX_DEPTH     = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jnv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jnv_out_t out_data
);

  // Depth counter holds 0..MAX_DEPTH; stack address covers 0..MAX_DEPTH-1.
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PW = POSITION_BITS;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  // ---------------------------------------------------------------------------
  // Stack organization
  //   entry depth-1 : tos_r (top of stack, 1 = curly, 0 = square)
  //   entry depth-2 : nos_r (next on stack)
  //   entries 0..depth-3 : stack memory
  // The memory is read every cycle at (next depth - 3), so after a pop the
  // new next-on-stack entry is already sitting in the read register. A push
  // spills nos_r into the memory at depth-2, which is the very address read
  // in that same cycle, so a one-entry bypass covers that case.
  // ---------------------------------------------------------------------------
  logic          stack_mem [2**AW];
  logic          rd_data_r;
  logic          fwd_hit_r;
  logic          fwd_data_r;
  logic          rd_val;

  // Scanner state
  phase_t        phase_r,  phase_nxt;
  logic [DW-1:0] depth_r,  depth_nxt;
  logic          quote_r,  quote_nxt;
  logic [PW-1:0] pos_r,    pos_nxt;
  logic          tos_r,    tos_nxt;
  logic          nos_r,    nos_nxt;

  // Output register plus skid entry
  jnv_out_t      out_data_r;
  logic          out_valid_r;
  jnv_out_t      skid_data_r;
  logic          skid_valid_r;

  jnv_out_t      res;
  logic          in_fire;
  logic          out_pop;
  logic          go_idle;
  logic          mem_we;
  logic [DW-1:0] wr_full;
  logic [DW-1:0] rd_full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          is_open;
  logic          is_close;
  logic          want_curly;
  logic [PW+15:0] pos_ext;
  logic [DW+6:0]  depth_ext;

  // Input side only stalls when the skid entry is occupied.
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_pop   = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_open    = (in_data.text_byte == CH_LBRACE) || (in_data.text_byte == CH_LBRACK);
  assign is_close   = (in_data.text_byte == CH_RBRACE) || (in_data.text_byte == CH_RBRACK);
  assign want_curly = (in_data.text_byte == CH_LBRACE) || (in_data.text_byte == CH_RBRACE);

  // Read data with bypass of last cycle's spill
  assign rd_val = fwd_hit_r ? fwd_data_r : rd_data_r;

  // ---------------------------------------------------------------------------
  // Per-byte decision, all from registered state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt     = phase_r;
    depth_nxt     = depth_r;
    quote_nxt     = quote_r;
    pos_nxt       = pos_r;
    tos_nxt       = tos_r;
    nos_nxt       = nos_r;
    mem_we        = 1'b0;
    go_idle       = 1'b0;
    res.status    = ST_SCAN;
    res.end_index = '0;
    pos_ext       = '0;

    if (in_fire) begin
      priority if (in_data.doc_start) begin
        // New document; anything in progress is dropped.
        pos_nxt = '0;
        if (is_open && !is_close) begin
          quote_nxt = 1'b0;
          depth_nxt = DW'(1);
          tos_nxt   = want_curly;
          phase_nxt = PH_SCAN;
        end else begin
          go_idle    = 1'b1;
          res.status = ST_OPENER;
        end
      end else if (phase_r != PH_SCAN) begin
        go_idle = 1'b1;
      end else if (pos_r == '1) begin
        go_idle    = 1'b1;
        res.status = ST_LONG;
      end else begin
        pos_nxt = pos_r + PW'(1);
        priority if (in_data.text_byte == CH_NUL) begin
          go_idle    = 1'b1;
          res.status = ST_ENDED;
        end else if (quote_r) begin
          if (in_data.text_byte == CH_QUOTE) begin
            quote_nxt = 1'b0;
          end
        end else if (in_data.text_byte == CH_QUOTE) begin
          quote_nxt = 1'b1;
        end else if (is_open) begin
          if (depth_r >= DEPTH_MAX) begin
            go_idle    = 1'b1;
            res.status = ST_DEEP;
          end else begin
            tos_nxt   = want_curly;
            nos_nxt   = tos_r;
            depth_nxt = depth_r + DW'(1);
            mem_we    = (depth_r >= DW'(2));
          end
        end else if (is_close) begin
          if (tos_r != want_curly) begin
            go_idle    = 1'b1;
            res.status = ST_MISMATCH;
          end else begin
            depth_nxt = depth_r - DW'(1);
            tos_nxt   = nos_r;
            nos_nxt   = rd_val;
            if (depth_r == DW'(1)) begin
              // Outermost closer: document complete.
              go_idle       = 1'b1;
              res.status    = ST_DONE;
              pos_ext       = {16'b0, pos_nxt};
              res.end_index = pos_ext[15:0];
            end
          end
        end else begin
          // Any other byte outside quotes just advances the position.
          quote_nxt = quote_r;
        end
      end
    end

    if (go_idle) begin
      phase_nxt = PH_IDLE;
      depth_nxt = '0;
      quote_nxt = 1'b0;
    end

    depth_ext      = {7'b0, depth_nxt};
    res.nest_depth = depth_ext[6:0];
  end

  // Spill address is depth-2, prefetch address is (next depth)-3.
  assign wr_full = depth_r - DW'(2);
  assign rd_full = depth_nxt - DW'(3);
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];

  // ---------------------------------------------------------------------------
  // Stack memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= nos_r;
    end
    rd_data_r  <= stack_mem[rd_addr];
    fwd_data_r <= nos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= mem_we && (wr_addr == rd_addr);
    end
  end

  // ---------------------------------------------------------------------------
  // Scanner state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      depth_r <= '0;
      quote_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      quote_r <= quote_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Top two stack entries are payload; only read while depth covers them.
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    nos_r <= nos_nxt;
  end

  // ---------------------------------------------------------------------------
  // Output register with skid entry. A result lands in the output register
  // when it is free or draining this cycle, else it parks in the skid entry.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (out_pop) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid_r || out_pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (out_pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

endmodule

// File: bench/json_nesting_validator_tb.sv
`timescale 1ns / 1ps

module json_nesting_validator_tb;
  import jnv_pkg::*;

  localparam int NEST_MAX    = 64;       // stack depth of the block
  localparam int OFFSET_MAX  = 16'hFFFF; // last offset that fits 16 bits
  localparam int STALL_LIMIT = 5000;     // cycles with no transaction at all
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int PRINT_CAP   = 50;       // mismatch lines printed at most

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  jnv_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  jnv_out_t out_data;

  json_nesting_validator #(
    .MAX_DEPTH    (NEST_MAX),
    .POSITION_BITS(16)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scanner shadow: what the block should hold after each byte transaction.
  // ---------------------------------------------------------------------------
  logic kind_stack [NEST_MAX];   // 1 = curly, 0 = square
  int   open_depth  = 0;
  bit   in_string   = 1'b0;
  bit   scanning    = 1'b0;
  int   byte_offset = 0;

  jnv_out_t expected_verdicts [$];
  int       mismatch_count = 0;

  // idle rates in percent; the receiver one is read by the ready process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // hold-off handshake between the stimulus and the ready process
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int doc_bytes    = 0;  // bytes sent inside random documents
  int stall_cycles = 0;

  // One byte in, one verdict out. Any verdict other than scanning closes the
  // document and leaves the scanner idle with depth and quote flag cleared.
  function automatic jnv_out_t predict_nesting(jnv_in_t item);
    jnv_out_t   res;
    logic [7:0] b;
    logic       want_curly;
    b = item.text_byte;
    res = '0;
    res.status = ST_SCAN;
    if (item.doc_start) begin
      // a start byte always abandons whatever was in progress
      open_depth  = 0;
      in_string   = 1'b0;
      scanning    = 1'b0;
      byte_offset = 0;
      if (b == CH_LBRACE || b == CH_LBRACK) begin
        kind_stack[0] = (b == CH_LBRACE);
        open_depth = 1;
        scanning = 1'b1;
      end else begin
        res.status = ST_OPENER;
      end
    end else if (!scanning) begin
      open_depth = 0;
      in_string = 1'b0;
    end else if (byte_offset >= OFFSET_MAX) begin
      // offset overflow wins over every other check on the byte
      res.status = ST_LONG;
    end else begin
      byte_offset++;
      if (b == CH_NUL) begin
        res.status = ST_ENDED;
      end else if (in_string) begin
        if (b == CH_QUOTE) in_string = 1'b0;
      end else if (b == CH_QUOTE) begin
        in_string = 1'b1;
      end else if (b == CH_LBRACE || b == CH_LBRACK) begin
        if (open_depth >= NEST_MAX) begin
          res.status = ST_DEEP;
        end else begin
          kind_stack[open_depth] = (b == CH_LBRACE);
          open_depth++;
        end
      end else if (b == CH_RBRACE || b == CH_RBRACK) begin
        want_curly = (b == CH_RBRACE);
        if (open_depth == 0 || kind_stack[open_depth-1] != want_curly) begin
          res.status = ST_MISMATCH;
        end else begin
          open_depth--;
          if (open_depth == 0) begin
            res.status = ST_DONE;
            res.end_index = byte_offset[15:0];
          end
        end
      end
    end
    if (res.status != ST_SCAN) begin
      scanning   = 1'b0;
      open_depth = 0;
      in_string  = 1'b0;
    end
    res.nest_depth = open_depth[6:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted byte, compare every accepted verdict.
  // Both sides sampled at the edge, before any nonblocking update lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    jnv_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_verdicts.push_back(predict_nesting(in_data));
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no byte transaction pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.end_index !== want.end_index)
            report_mismatch($sformatf("end_index got %0d want %0d",
                                      out_data.end_index, want.end_index));
          if (out_data.nest_depth !== want.nest_depth)
            report_mismatch($sformatf("nest_depth got %0d want %0d",
                                      out_data.nest_depth, want.nest_depth));
        end
      end
    end
  end

  // Receiver: random ready, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // One byte transaction. Entered and left at a rising edge; valid is only
  // dropped when an idle gap is taken.
  task automatic send_byte(input logic [7:0] b, input logic first);
    jnv_in_t item;
    item.text_byte = b;
    item.doc_start = first;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // First character carries the start flag.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_verdicts.size() != 0);
    @(posedge clk);
  endtask

  // nonzero byte with no meaning to the scanner
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_QUOTE || b == CH_LBRACE || b == CH_LBRACK ||
           b == CH_RBRACE || b == CH_RBRACK);
    return b;
  endfunction

  function automatic logic [7:0] random_opener();
    return $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
  endfunction

  // Mostly balanced text with random content; corrupt docs get stray bytes
  // of any value, including zero and start-flagged ones.
  task automatic send_random_document(input int budget, input int open_pct,
                                      input bit corrupt);
    bit         kinds [$];
    int         n;
    int         r;
    logic [7:0] b;
    b = random_opener();
    kinds.push_back(b == CH_LBRACE);
    send_byte(b, 1'b1);
    n = 1;
    while (kinds.size() != 0 && n < budget) begin
      r = $urandom_range(99);
      if (corrupt && r < 4) begin
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        n++;
      end else if (r < open_pct) begin
        b = random_opener();
        kinds.push_back(b == CH_LBRACE);
        send_byte(b, 1'b0);
        n++;
      end else if (r < open_pct + 25) begin
        b = kinds[$] ? CH_RBRACE : CH_RBRACK;
        void'(kinds.pop_back());
        send_byte(b, 1'b0);
        n++;
      end else if (r < open_pct + 35) begin
        // quoted run; delimiters inside must be skipped
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
          send_byte(b, 1'b0);
          n++;
        end
        send_byte(CH_QUOTE, 1'b0);
        n += 2;
      end else begin
        send_byte(plain_byte(), 1'b0);
        n++;
      end
    end
    doc_bytes += n;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    set_idling(10, 84);
    send_text("{}");
    send_text("[]");
    send_text("{[]}");
    send_text("[}");                       // wrong closer
    send_text("{]");
    send_byte(8'hFF, 1'b1);                // start byte not an opener
    send_byte(CH_NUL, 1'b1);
    send_byte(8'hFF, 1'b0);                // idle: ignored
    send_byte(CH_RBRACE, 1'b0);
    send_text("[");
    send_byte(CH_NUL, 1'b0);               // text ends mid-document
    send_text("{\"a");
    send_byte(CH_NUL, 1'b0);               // text ends inside quotes
    send_text("[\"}]{\"]");                // delimiters hidden in a string
    send_text("[{");
    send_text("{}");                       // restart abandons the open doc
    wait_drained();
  endtask

  task automatic test_deep_nesting();
    bit         kinds [$];
    logic [7:0] b;
    set_idling(84, 10);
    // fill to the limit, openers in quotes don't count, then one too many
    send_byte(CH_LBRACE, 1'b1);
    repeat (NEST_MAX - 1) send_byte(random_opener(), 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_LBRACK, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_LBRACK, 1'b0);
    // full depth, then unwound completely
    for (int i = 0; i < NEST_MAX; i++) begin
      b = random_opener();
      kinds.push_back(b == CH_LBRACE);
      send_byte(b, i == 0);
    end
    while (kinds.size() != 0) begin
      b = kinds[$] ? CH_RBRACE : CH_RBRACK;
      void'(kinds.pop_back());
      send_byte(b, 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    send_byte(CH_LBRACK, 1'b1);
    repeat (40) send_byte(plain_byte(), 1'b0);
    send_byte(CH_RBRACK, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_documents(input int send_pct, input int recv_pct,
                                       input int target);
    int  first;
    bit  deep;
    set_idling(send_pct, recv_pct);
    first = doc_bytes;
    while (doc_bytes - first < target) begin
      deep = ($urandom_range(19) == 0);
      send_random_document(deep ? 300 : $urandom_range(2, 30),
                           deep ? 70 : $urandom_range(15, 40),
                           $urandom_range(9) == 0);
      // stray bytes between documents
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_deep_nesting();
    test_back_pressure();
    test_random_documents(10, 84, 330);
    test_random_documents(84, 10, 330);
    test_random_documents(0, 0, 330);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
